@@ sv/rct_pkg.sv @@
// Package: widths and codes for the rectangle collision test.
package rct_pkg;
    localparam int COORD_BITS     = 24;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int HALF_BITS      = COORD_BITS - 1;
    localparam int TRIG_BITS      = TRIG_FRAC_BITS + 2;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS      = DIFF_BITS + TRIG_BITS + 1;
    localparam int ROT_BITS       = 2 * TRIG_BITS + 1;
    localparam int WIDE_BITS      = 128;

    localparam logic [1:0] MODE_RECT   = 2'd0;
    localparam logic [1:0] MODE_CIRCLE = 2'd1;
    localparam logic [1:0] MODE_RSVD2  = 2'd2;
    localparam logic [1:0] MODE_RSVD3  = 2'd3;

    // Kind of test carried down the pipeline
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_ALIGNED = 2'd1;
    localparam logic [1:0] KIND_SAT     = 2'd2;
    localparam logic [1:0] KIND_CIRCLE  = 2'd3;

    localparam logic [2:0] REG_CX  = 3'd0;
    localparam logic [2:0] REG_CY  = 3'd1;
    localparam logic [2:0] REG_HL  = 3'd2;
    localparam logic [2:0] REG_HW  = 3'd3;
    localparam logic [2:0] REG_COS = 3'd4;
    localparam logic [2:0] REG_SIN = 3'd5;
    localparam logic [2:0] REG_AA  = 3'd6;

    localparam int CFG_DATA_BITS = COORD_BITS;
endpackage

@@ sv/rect_collision_test.sv @@
// Top level: pipelined collision test of a configured rectangle against probe shapes.
// An accepted input transaction is registered in stages one, two, three and four before collides is shown.
// Throughput: one transaction per cycle; each stage advances when the next can take it.
// Products are formed in stage one, sums and clamps in stage two, scaling and partial
// squares in stage three, final sums and compares in stage four (output register).
// Reset: rst_n clears valid bits and loads the register reset values.
module rect_collision_test (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [2:0]                            cfg_index,
    input  logic [rct_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            mode,
    input  logic                                  probe_valid,
    input  logic signed [rct_pkg::COORD_BITS-1:0] probe_center_x,
    input  logic signed [rct_pkg::COORD_BITS-1:0] probe_center_y,
    input  logic [rct_pkg::HALF_BITS-1:0]         probe_half_length,
    input  logic [rct_pkg::HALF_BITS-1:0]         probe_half_width,
    input  logic signed [rct_pkg::TRIG_BITS-1:0]  probe_cos,
    input  logic signed [rct_pkg::TRIG_BITS-1:0]  probe_sin,
    input  logic                                  probe_axis_aligned,
    input  logic [rct_pkg::HALF_BITS-1:0]         probe_radius,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  collides
);
    localparam int CB = rct_pkg::COORD_BITS;
    localparam int HB = rct_pkg::HALF_BITS;
    localparam int TB = rct_pkg::TRIG_BITS;
    localparam int F  = rct_pkg::TRIG_FRAC_BITS;
    localparam int DB = rct_pkg::DIFF_BITS;
    localparam int PB = rct_pkg::PROD_BITS;
    localparam int RB = rct_pkg::ROT_BITS;
    // Width of a rotated offset sum and its magnitude
    localparam int SB = PB + 1;

    // Configuration registers
    logic signed [CB-1:0] cx_reg, cy_reg;
    logic [HB-1:0]        hl_reg, hw_reg;
    logic signed [TB-1:0] c_reg, s_reg;
    logic                 aa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            hl_reg <= '0;
            hw_reg <= '0;
            c_reg  <= TB'(1 << F);
            s_reg  <= '0;
            aa_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rct_pkg::REG_CX:  cx_reg <= cfg_data[CB-1:0];
                rct_pkg::REG_CY:  cy_reg <= cfg_data[CB-1:0];
                rct_pkg::REG_HL:  hl_reg <= cfg_data[HB-1:0];
                rct_pkg::REG_HW:  hw_reg <= cfg_data[HB-1:0];
                rct_pkg::REG_COS: c_reg  <= cfg_data[TB-1:0];
                rct_pkg::REG_SIN: s_reg  <= cfg_data[TB-1:0];
                rct_pkg::REG_AA:  aa_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline control: a stage advances when empty or when its successor advances
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;
    assign adv4 = !v4_reg || out_ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ready  = adv1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: offsets and all first-order products
    logic signed [DB-1:0] sx, sy;
    assign sx = DB'(probe_center_x) - DB'(cx_reg);
    assign sy = DB'(probe_center_y) - DB'(cy_reg);

    logic [1:0]   k1_reg;   // kind of test for this transaction
    logic signed [PB-1:0] sxc_reg, sys_reg, sxs_reg, syc_reg;
    logic signed [PB-1:0] sxoc_reg, syos_reg, sxos_reg, syoc_reg;
    logic signed [RB-1:0] occ_reg, oss_reg, osc_reg, ocs_reg;
    logic signed [DB-1:0] sx1_reg, sy1_reg;
    logic [HB-1:0] ohl1_reg, ohw1_reg, rad1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            if (!probe_valid) k1_reg <= rct_pkg::KIND_NONE;
            else if (mode == rct_pkg::MODE_RECT)
                k1_reg <= (aa_reg && probe_axis_aligned) ? rct_pkg::KIND_ALIGNED
                                                         : rct_pkg::KIND_SAT;
            else if (mode == rct_pkg::MODE_CIRCLE) k1_reg <= rct_pkg::KIND_CIRCLE;
            else k1_reg <= rct_pkg::KIND_NONE;
            sxc_reg  <= PB'(sx * c_reg);
            sys_reg  <= PB'(sy * s_reg);
            sxs_reg  <= PB'(sx * s_reg);
            syc_reg  <= PB'(sy * c_reg);
            sxoc_reg <= PB'(sx * probe_cos);
            syos_reg <= PB'(sy * probe_sin);
            sxos_reg <= PB'(sx * probe_sin);
            syoc_reg <= PB'(sy * probe_cos);
            occ_reg  <= RB'(probe_cos * c_reg);
            oss_reg  <= RB'(probe_sin * s_reg);
            osc_reg  <= RB'(probe_sin * c_reg);
            ocs_reg  <= RB'(probe_cos * s_reg);
            sx1_reg  <= sx;
            sy1_reg  <= sy;
            ohl1_reg <= probe_half_length;
            ohw1_reg <= probe_half_width;
            rad1_reg <= probe_radius;
        end
    end

    // Stage 2: rotated sums, their magnitudes, circle clamp, aligned test
    function automatic logic [SB-1:0] mag_s(input logic signed [SB-1:0] v);
        mag_s = v[SB-1] ? SB'(-v) : v;
    endfunction

    logic signed [SB-1:0] a1, a2, a3, a4, ry_s;
    logic signed [RB:0]   b1, b2;
    assign a1   = SB'(sxc_reg) + SB'(sys_reg);
    assign a2   = SB'(sxs_reg) - SB'(syc_reg);
    assign a3   = SB'(sxoc_reg) + SB'(syos_reg);
    assign a4   = SB'(sxos_reg) - SB'(syoc_reg);
    assign ry_s = SB'(syc_reg) - SB'(sxs_reg);
    assign b1   = (RB+1)'(occ_reg) + (RB+1)'(oss_reg);
    assign b2   = (RB+1)'(osc_reg) - (RB+1)'(ocs_reg);

    logic [SB-1:0] hx, hy, rx, ry;
    assign hx = SB'(hl_reg) << F;
    assign hy = SB'(hw_reg) << F;
    assign rx = mag_s(a1);
    assign ry = mag_s(ry_s);

    logic [DB-1:0] msx, msy;
    assign msx = sx1_reg[DB-1] ? DB'(-sx1_reg) : DB'(sx1_reg);
    assign msy = sy1_reg[DB-1] ? DB'(-sy1_reg) : DB'(sy1_reg);

    logic [1:0] k2_reg;
    logic aa_hit2_reg;
    logic [SB-1:0] m1_reg, m2_reg, m3_reg, m4_reg, ux_reg, uy_reg;
    logic [RB:0] mb1_reg, mb2_reg;
    logic [HB-1:0] ohl2_reg, ohw2_reg, rad2_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            k2_reg      <= k1_reg;
            aa_hit2_reg <= (msx < DB'(hl_reg) + DB'(ohl1_reg)) &&
                           (msy < DB'(hw_reg) + DB'(ohw1_reg));
            m1_reg   <= mag_s(a1);
            m2_reg   <= mag_s(a2);
            m3_reg   <= mag_s(a3);
            m4_reg   <= mag_s(a4);
            mb1_reg  <= b1[RB] ? (RB+1)'(-b1) : b1;
            mb2_reg  <= b2[RB] ? (RB+1)'(-b2) : b2;
            ux_reg   <= (rx > hx) ? rx - hx : '0;
            uy_reg   <= (ry > hy) ? ry - hy : '0;
            ohl2_reg <= ohl1_reg;
            ohw2_reg <= ohw1_reg;
            rad2_reg <= rad1_reg;
        end
    end

    // Stage 3: half size times axis projections, partial squares for the circle.
    // Each clamped offset is split into a high and a low half so that no
    // squaring multiplier for the circle is wider than the halves.
    localparam int HPB = HB + RB + 1;
    localparam int SQB = 2 * SB;
    localparam int LOB = SB / 2;
    localparam int HIB = SB - LOB;
    logic [1:0] k3_reg;
    logic aa_hit3_reg;
    logic [HPB-1:0] p_ohl_b1, p_ohw_b2, p_ohl_b2, p_ohw_b1;
    logic [HPB-1:0] p_hl_b1, p_hw_b2, p_hl_b2, p_hw_b1;
    logic [SB-1:0] m1_3, m2_3, m3_3, m4_3;
    logic [2*HIB-1:0]   uxhh_reg, uyhh_reg;
    logic [HIB+LOB-1:0] uxhl_reg, uyhl_reg;
    logic [2*LOB-1:0]   uxll_reg, uyll_reg;
    logic [2*HB-1:0]    rr_reg;
    logic [HB-1:0] ohl3_reg, ohw3_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            k3_reg      <= k2_reg;
            aa_hit3_reg <= aa_hit2_reg;
            p_ohl_b1 <= HPB'(ohl2_reg * mb1_reg);
            p_ohw_b2 <= HPB'(ohw2_reg * mb2_reg);
            p_ohl_b2 <= HPB'(ohl2_reg * mb2_reg);
            p_ohw_b1 <= HPB'(ohw2_reg * mb1_reg);
            p_hl_b1  <= HPB'(hl_reg * mb1_reg);
            p_hw_b2  <= HPB'(hw_reg * mb2_reg);
            p_hl_b2  <= HPB'(hl_reg * mb2_reg);
            p_hw_b1  <= HPB'(hw_reg * mb1_reg);
            m1_3 <= m1_reg;
            m2_3 <= m2_reg;
            m3_3 <= m3_reg;
            m4_3 <= m4_reg;
            uxhh_reg <= (2*HIB)'(ux_reg[SB-1:LOB] * ux_reg[SB-1:LOB]);
            uxhl_reg <= (HIB+LOB)'(ux_reg[SB-1:LOB] * ux_reg[LOB-1:0]);
            uxll_reg <= (2*LOB)'(ux_reg[LOB-1:0] * ux_reg[LOB-1:0]);
            uyhh_reg <= (2*HIB)'(uy_reg[SB-1:LOB] * uy_reg[SB-1:LOB]);
            uyhl_reg <= (HIB+LOB)'(uy_reg[SB-1:LOB] * uy_reg[LOB-1:0]);
            uyll_reg <= (2*LOB)'(uy_reg[LOB-1:0] * uy_reg[LOB-1:0]);
            rr_reg   <= (2*HB)'(rad2_reg * rad2_reg);
            ohl3_reg <= ohl2_reg;
            ohw3_reg <= ohw2_reg;
        end
    end

    // Stage 4: compares; every side brought to a 2^(2F) scale
    localparam int CMB = HPB + 2;
    function automatic logic axis_ok(input logic [SB-1:0] m, input logic [HPB-1:0] pa,
                                     input logic [HPB-1:0] pb, input logic [HB-1:0] h);
        logic [CMB-1:0] l, r;
        l = CMB'(m) << F;
        r = CMB'(pa) + CMB'(pb) + (CMB'(h) << (2 * F));
        axis_ok = (l <= r);
    endfunction

    // Rebuild the squared distance from its partial products
    logic [SQB:0] usq;
    assign usq = ((SQB+1)'(uxhh_reg) << (2 * LOB)) + ((SQB+1)'(uxhl_reg) << (LOB + 1))
               + (SQB+1)'(uxll_reg)
               + ((SQB+1)'(uyhh_reg) << (2 * LOB)) + ((SQB+1)'(uyhl_reg) << (LOB + 1))
               + (SQB+1)'(uyll_reg);

    logic sat_hit, circ_hit, hit;
    assign sat_hit = axis_ok(m1_3, p_ohl_b1, p_ohw_b2, hl_reg) &&
                     axis_ok(m2_3, p_ohl_b2, p_ohw_b1, hw_reg) &&
                     axis_ok(m3_3, p_hl_b1, p_hw_b2, ohl3_reg) &&
                     axis_ok(m4_3, p_hl_b2, p_hw_b1, ohw3_reg);
    assign circ_hit = usq < ((SQB+1)'(rr_reg) << (2 * F));

    always_comb
    begin
        case (k3_reg)
            rct_pkg::KIND_ALIGNED: hit = aa_hit3_reg;
            rct_pkg::KIND_SAT:     hit = sat_hit;
            rct_pkg::KIND_CIRCLE:  hit = circ_hit;
            default:               hit = 1'b0;
        endcase
    end

    logic hit_reg;
    always_ff @(posedge clk)
    begin
        if (adv4) hit_reg <= hit;
    end
    assign collides = hit_reg;

    // Hold the result while the consumer stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(collides))
        else $error("result changed under stall");
    // A stalled full pipe accepts nothing
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && v4_reg && !out_ready |-> !in_ready)
        else $error("accept into full pipeline");
    // A bubble-free stage feeds the next one in the following cycle
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && adv4 |=> v4_reg)
        else $error("transaction lost between stages");
endmodule

@@ bench/rect_collision_test_test.sv @@
// Testbench for rect_collision_test: directed and randomised probes checked against an exact predictor.
module rect_collision_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS     = rct_pkg::COORD_BITS;
    localparam int HALF_BITS      = rct_pkg::HALF_BITS;
    localparam int TRIG_BITS      = rct_pkg::TRIG_BITS;
    localparam int TRIG_FRAC_BITS = rct_pkg::TRIG_FRAC_BITS;
    localparam int CFG_DATA_BITS  = rct_pkg::CFG_DATA_BITS;

    typedef struct {
        logic [1:0]                  mode;
        logic                        pv;
        logic signed [COORD_BITS-1:0] px, py;
        logic [HALF_BITS-1:0]        hl, hw, rad;
        logic signed [TRIG_BITS-1:0] oc, os;
        logic                        oa;
    } probe_t;

    // Configured rectangle, as the predictor sees it
    typedef struct {
        logic signed [COORD_BITS-1:0] cx, cy;
        logic [HALF_BITS-1:0]         hl, hw;
        logic signed [TRIG_BITS-1:0]  c, s;
        logic                         aa;
    } rect_t;

    // |lhs| * 2^F <= h1*|b1| + h2*|b2| + h3 * 2^(2F)
    function automatic bit axis_clear(logic signed [127:0] lhs, logic [127:0] h1,
                                      logic signed [127:0] b1, logic [127:0] h2,
                                      logic signed [127:0] b2, logic [127:0] h3);
        logic [127:0] l, r;
        l = (lhs < 0 ? -lhs : lhs) << TRIG_FRAC_BITS;
        r = h1 * (b1 < 0 ? -b1 : b1) + h2 * (b2 < 0 ? -b2 : b2)
            + (h3 << (2 * TRIG_FRAC_BITS));
        return l <= r;
    endfunction

    function automatic bit overlap_of(rect_t r, probe_t p);
        logic signed [127:0] sx, sy, c, s, oc, os, b1, b2, rx, ry;
        logic [127:0] ux, uy, hx, hy, rs;
        sx = 128'(signed'(p.px)) - 128'(signed'(r.cx));
        sy = 128'(signed'(p.py)) - 128'(signed'(r.cy));
        c = r.c; s = r.s; oc = p.oc; os = p.os;
        if (!p.pv) return 0;
        if (p.mode == rct_pkg::MODE_RECT) begin
            if (r.aa && p.oa)
                return ((sx < 0 ? -sx : sx) < 128'(r.hl) + 128'(p.hl)) &&
                       ((sy < 0 ? -sy : sy) < 128'(r.hw) + 128'(p.hw));
            b1 = oc * c + os * s;
            b2 = os * c - oc * s;
            return axis_clear(sx * c + sy * s, p.hl, b1, p.hw, b2, r.hl) &&
                   axis_clear(sx * s - sy * c, p.hl, b2, p.hw, b1, r.hw) &&
                   axis_clear(sx * oc + sy * os, r.hl, b1, r.hw, b2, p.hl) &&
                   axis_clear(sx * os - sy * oc, r.hl, b2, r.hw, b1, p.hw);
        end
        if (p.mode == rct_pkg::MODE_CIRCLE) begin
            rx = sx * c + sy * s;  rx = rx < 0 ? -rx : rx;
            ry = sy * c - sx * s;  ry = ry < 0 ? -ry : ry;
            hx = 128'(r.hl) << TRIG_FRAC_BITS;
            hy = 128'(r.hw) << TRIG_FRAC_BITS;
            ux = rx > hx ? rx - hx : 0;
            uy = ry > hy ? ry - hy : 0;
            rs = 128'(p.rad) << TRIG_FRAC_BITS;
            return ux * ux + uy * uy < rs * rs;
        end
        return 0;
    endfunction

    class collision_scoreboard;
        bit    pending[$];
        int    errors, checked, hits;
        function void note_probe(rect_t r, probe_t p);
            pending.push_back(overlap_of(r, p));
        endfunction
        function void check_result(logic got);
            bit want;
            if (pending.size() == 0) begin
                $error("collides: result with nothing pending, actual %0b", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got) hits++;
            if (got !== want) begin
                $error("collides: expected %0b actual %0b", want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = rct_pkg::REG_CX;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 0, out_ready = 0;
    logic in_ready, out_valid, collides;
    probe_t drv = '{default: '0};
    rect_t  rect;
    collision_scoreboard sb = new();
    bit hold_off = 0;
    int stall_bias = 0;  // raise to lengthen receiver stalls

    rect_collision_test u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .mode(drv.mode), .probe_valid(drv.pv), .probe_center_x(drv.px),
        .probe_center_y(drv.py), .probe_half_length(drv.hl),
        .probe_half_width(drv.hw), .probe_cos(drv.oc), .probe_sin(drv.os),
        .probe_axis_aligned(drv.oa), .probe_radius(drv.rad),
        .out_valid(out_valid), .out_ready(out_ready), .collides(collides)
    );

    initial forever #4 clk = ~clk;

    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 19) == 0 ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // Receiver: accept results, idle at random, and hold off on request
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) sb.check_result(collides);
            if (hold_off) out_ready <= 0;
            else if (stall_bias == 0 && $urandom_range(0, 3) != 0) out_ready <= 1;
            else begin
                g = gap_len();
                out_ready <= (g == 0);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            rct_pkg::REG_CX:  rect.cx = val;
            rct_pkg::REG_CY:  rect.cy = val;
            rct_pkg::REG_HL:  rect.hl = val[HALF_BITS-1:0];
            rct_pkg::REG_HW:  rect.hw = val[HALF_BITS-1:0];
            rct_pkg::REG_COS: rect.c  = val[TRIG_BITS-1:0];
            rct_pkg::REG_SIN: rect.s  = val[TRIG_BITS-1:0];
            default: rect.aa = val[0];
        endcase
    endtask

    // Offer one probe and hold it until the block takes it; valid stays up
    // across back-to-back probes and drops only for a gap
    task automatic send_probe(probe_t p, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        drv <= p; in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        sb.note_probe(rect, p);
    endtask

    task automatic drain();
        int n;
        n = 0;
        in_valid <= 0;
        while (sb.pending.size() != 0 && n < 20000) begin @(posedge clk); n++; end
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [TRIG_BITS-1:0] trig_val();
        case ($urandom_range(0, 5))
            0: return 16'sh4000;
            1: return -16'sh4000;
            2: return 0;
            3: return 16'sh8000;  // most negative code, outside the unit circle
            4: return TRIG_BITS'($urandom);
            default: return TRIG_BITS'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [HALF_BITS-1:0] half_val();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return {HALF_BITS{1'b1}};
            2: return HALF_BITS'($urandom);
            default: return HALF_BITS'($urandom_range(0, 4000));
        endcase
    endfunction

    // Probe mostly placed near the rectangle so that both outcomes occur
    function automatic probe_t random_probe();
        probe_t p;
        int r;
        r = $urandom_range(0, 19);
        p.mode = r < 9 ? rct_pkg::MODE_RECT :
                 (r < 18 ? rct_pkg::MODE_CIRCLE : 2'($urandom_range(2, 3)));
        p.pv  = $urandom_range(0, 15) != 0;
        if ($urandom_range(0, 9) == 0) begin
            p.px = COORD_BITS'($urandom);
            p.py = COORD_BITS'($urandom);
        end else begin
            p.px = rect.cx + COORD_BITS'($signed($urandom_range(0, 16000)) - 8000);
            p.py = rect.cy + COORD_BITS'($signed($urandom_range(0, 16000)) - 8000);
        end
        p.hl = half_val(); p.hw = half_val(); p.rad = half_val();
        p.oc = trig_val(); p.os = trig_val();
        p.oa = 1'($urandom_range(0, 1));
        return p;
    endfunction

    task automatic random_rect(int kind);
        write_reg(rct_pkg::REG_CX, kind == 0 ? {1'b1, {CFG_DATA_BITS-1{1'b0}}} :
                  (kind == 1 ? {1'b0, {CFG_DATA_BITS-1{1'b1}}} : CFG_DATA_BITS'($urandom)));
        write_reg(rct_pkg::REG_CY, kind == 0 ? {CFG_DATA_BITS{1'b1}} :
                  CFG_DATA_BITS'($urandom));
        write_reg(rct_pkg::REG_HL, kind == 1 ? {CFG_DATA_BITS{1'b1}} :
                  CFG_DATA_BITS'($urandom_range(0, 3000)));
        write_reg(rct_pkg::REG_HW, kind == 0 ? CFG_DATA_BITS'(0) :
                  CFG_DATA_BITS'($urandom_range(0, 3000)));
        write_reg(rct_pkg::REG_COS, CFG_DATA_BITS'(kind == 0 ? 16'sh8000 : trig_val()));
        write_reg(rct_pkg::REG_SIN, CFG_DATA_BITS'(kind == 1 ? 16'sh4000 : trig_val()));
        write_reg(rct_pkg::REG_AA, kind == 2 ? CFG_DATA_BITS'(1) :
                  CFG_DATA_BITS'($urandom_range(0, 1)));
    endtask

    initial
    begin
        probe_t p;
        rect = '{cx: 0, cy: 0, hl: 0, hw: 0, c: 16'sh4000, s: 0, aa: 1};
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // Directed: an axis-aligned rectangle at the origin, half sizes 100 and 50
        write_reg(rct_pkg::REG_HL, 100);
        write_reg(rct_pkg::REG_HW, 50);
        p = '{mode: rct_pkg::MODE_RECT, pv: 1, px: 150, py: 0, hl: 50, hw: 10,
              rad: 0, oc: 16'sh4000, os: 0, oa: 1};
        send_probe(p, 0);            // touching edges: strict test says no
        p.px = 149; send_probe(p, 0);
        p.pv = 0; send_probe(p, 0);  // invalid probe
        p.pv = 1; p.mode = rct_pkg::MODE_RSVD2; send_probe(p, 0);
        p.mode = rct_pkg::MODE_RSVD3; send_probe(p, 0);
        p.mode = rct_pkg::MODE_RECT; p.oa = 0; p.px = 150; send_probe(p, 0); // non-strict SAT
        p.oc = 16'sh8000; p.os = 16'sh8000; send_probe(p, 0);
        p.px = {1'b1, 23'd0}; p.py = {1'b0, {23{1'b1}}};
        p.hl = '1; p.hw = '1; send_probe(p, 0);
        p.oa = 1; send_probe(p, 0);
        p = '{mode: rct_pkg::MODE_CIRCLE, pv: 1, px: 0, py: 0, hl: 0, hw: 0,
              rad: 0, oc: 0, os: 0, oa: 0};
        send_probe(p, 0);            // zero radius never hits
        p.rad = 1; send_probe(p, 0);
        p.px = 130; p.py = 90; p.rad = 50; send_probe(p, 0); // corner, exactly on
        p.rad = 51; send_probe(p, 0);
        p.rad = '1; p.px = {1'b1, 23'd0}; p.py = {1'b1, 23'd0}; send_probe(p, 0);
        drain();

        // Extreme and random settings, then random probes, with gaps but for setting 1
        for (int ph = 0; ph < 7; ph++)
        begin
            random_rect(ph);
            for (int i = 0; i < 250; i++)
            begin
                if (ph == 3 && i == 20) begin
                    hold_off = 1;
                    fork
                        begin repeat (60) @(posedge clk); hold_off = 0; end
                    join_none
                end
                stall_bias = (ph == 5) ? 1 : 0;
                send_probe(random_probe(), ph != 1);
            end
            drain();
        end

        $display("Covered %0d results (%0d hits) over 8 rectangle settings,",
                 sb.checked, sb.hits);
        $display("rectangle, circle, unsupported and invalid probes with stalls.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
